/* src/eps_pkg.sv */
// ----------------------------------------------------------------------------
// eps_pkg: shared types and constants of the encoder PI speed controller
// Item structs, configuration register map, reset values and the
// command/status groups between sequencer and datapath.
// ----------------------------------------------------------------------------
package eps_pkg;

  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned PER_W      = 16;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned TICK_W     = 8;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned TGT_W      = 8;
  localparam int unsigned POT_W      = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // speed error (target + trim - speed) fits 18 bits signed
  localparam int unsigned DIFF_W  = 18;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned MUL_A_W = GAIN_W + 1;
  localparam int unsigned MUL_B_W = ACC_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  localparam int unsigned DIV_STEPS = SCALE_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // setpoint trim: (pot - 512) / 51 via reciprocal multiply, exact for |d| <= 512
  localparam int unsigned RECIP_W    = 11;
  localparam int unsigned TRIM_SHIFT = 16;
  localparam int unsigned TRIM_W     = 5;
  localparam logic [RECIP_W-1:0] TRIM_RECIP = 11'd1286;
  localparam logic [POT_W-1:0]   POT_MID    = 10'd512;

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
  localparam logic [DUTY_W-1:0]  DUTY_MAX  = '1;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_KP         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DT_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS      = 3'd6;

  localparam logic [GAIN_W-1:0]  KP_RST    = 16'd768;
  localparam logic [GAIN_W-1:0]  KI_RST    = 16'd2560;
  localparam logic [GAIN_W-1:0]  DT_RST    = 16'd33;
  localparam logic [PER_W-1:0]   PMIN_RST  = 16'd330;
  localparam logic [PER_W-1:0]   PMAX_RST  = 16'd15625;
  localparam logic [SCALE_W-1:0] SCALE_RST = 24'd1250000;
  localparam logic [TICK_W-1:0]  TICKS_RST = 8'd2;

  typedef struct packed {
    logic               opcode;
    logic [PHASE_W-1:0] encoder_phase;
    logic [PER_W-1:0]   period_ticks;
    logic [TGT_W-1:0]   target_speed;
    logic [POT_W-1:0]   pot_sample;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  pwm_duty;
    logic [SPEED_W-1:0] measured_speed;
    logic               duty_updated;
  } out_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  dt_step;
    logic [PER_W-1:0]   period_min;
    logic [PER_W-1:0]   period_max;
    logic [SCALE_W-1:0] speed_scale;
    logic [TICK_W-1:0]  ticks_per_update;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic phase;
    logic div_step;
    logic spd_load;
    logic pi_diff;
    logic pi_mul_dt;
    logic pi_mul_kp;
    logic pi_mul_ki;
    logic pi_duty;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic upd;
  } dp_status_t;

endpackage

/* src/eps_cfg.sv */
// ----------------------------------------------------------------------------
// eps_cfg: configuration register file
// Decodes the write port into the seven control registers.
// ----------------------------------------------------------------------------
module eps_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [eps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [eps_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output eps_pkg::cfg_t                       cfg_o
);

  eps_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp               <= eps_pkg::KP_RST;
      cfg_q.ki               <= eps_pkg::KI_RST;
      cfg_q.dt_step          <= eps_pkg::DT_RST;
      cfg_q.period_min       <= eps_pkg::PMIN_RST;
      cfg_q.period_max       <= eps_pkg::PMAX_RST;
      cfg_q.speed_scale      <= eps_pkg::SCALE_RST;
      cfg_q.ticks_per_update <= eps_pkg::TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        eps_pkg::REG_KP:         cfg_q.kp <= cfg_data_i[eps_pkg::GAIN_W-1:0];
        eps_pkg::REG_KI:         cfg_q.ki <= cfg_data_i[eps_pkg::GAIN_W-1:0];
        eps_pkg::REG_DT_STEP:    cfg_q.dt_step <= cfg_data_i[eps_pkg::GAIN_W-1:0];
        eps_pkg::REG_PERIOD_MIN: cfg_q.period_min <= cfg_data_i[eps_pkg::PER_W-1:0];
        eps_pkg::REG_PERIOD_MAX: cfg_q.period_max <= cfg_data_i[eps_pkg::PER_W-1:0];
        eps_pkg::REG_SCALE:      cfg_q.speed_scale <= cfg_data_i[eps_pkg::SCALE_W-1:0];
        eps_pkg::REG_TICKS:      cfg_q.ticks_per_update <= cfg_data_i[eps_pkg::TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/eps_ctrl.sv */
// ----------------------------------------------------------------------------
// eps_ctrl: item sequencer
// Walks each item through edge/tick update, restoring division, the
// optional PI steps and the output register handoff.
// ----------------------------------------------------------------------------
module eps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output eps_pkg::dp_cmd_t    cmd_o,
  input  eps_pkg::dp_status_t status_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PHASE = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_SPD   = 4'd3;
  localparam logic [3:0] S_DIFF  = 4'd4;
  localparam logic [3:0] S_MDT   = 4'd5;
  localparam logic [3:0] S_MKP   = 4'd6;
  localparam logic [3:0] S_MKI   = 4'd7;
  localparam logic [3:0] S_DUTY  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_q, state_d;
  logic [eps_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_PHASE;
        end
      end
      S_PHASE: begin
        cmd_o.phase = 1'b1;
        cnt_d       = eps_pkg::DIV_CNT_W'(eps_pkg::DIV_STEPS - 1);
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_SPD;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_SPD: begin
        cmd_o.spd_load = 1'b1;
        state_d        = status_i.upd ? S_DIFF : S_OUT;
      end
      S_DIFF: begin
        cmd_o.pi_diff = 1'b1;
        state_d       = S_MDT;
      end
      S_MDT: begin
        cmd_o.pi_mul_dt = 1'b1;
        state_d         = S_MKP;
      end
      S_MKP: begin
        cmd_o.pi_mul_kp = 1'b1;
        state_d         = S_MKI;
      end
      S_MKI: begin
        cmd_o.pi_mul_ki = 1'b1;
        state_d         = S_DUTY;
      end
      S_DUTY: begin
        cmd_o.pi_duty = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* src/eps_dp.sv */
// ----------------------------------------------------------------------------
// eps_dp: controller datapath
// Period ring and running total, tick counter, bit-serial speed divider,
// shared PI multiplier, duty clamp and output register.
// ----------------------------------------------------------------------------
module eps_dp #(
  parameter int unsigned PERIOD_SLOTS  = 16,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  eps_pkg::cfg_t       cfg_i,
  input  eps_pkg::in_item_t   in_data_i,
  input  eps_pkg::dp_cmd_t    cmd_i,
  output eps_pkg::dp_status_t status_o,
  output eps_pkg::out_item_t  out_data_o
);

  localparam int unsigned SLOT_W  = (PERIOD_SLOTS > 1) ? $clog2(PERIOD_SLOTS) : 1;
  localparam int unsigned TOTAL_W = eps_pkg::PER_W + SLOT_W;
  localparam int unsigned ACC_W   = eps_pkg::ACC_W;
  localparam int unsigned PROD_W  = eps_pkg::PROD_W;
  localparam int unsigned DIFF_W  = eps_pkg::DIFF_W;
  localparam int unsigned MUL_B_W = eps_pkg::MUL_B_W;
  localparam int unsigned TRIM_W  = eps_pkg::TRIM_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PERIOD_SLOTS - 1);
  localparam logic signed [PROD_W-1:0] RND = $signed(PROD_W'(1) << (FRACTION_BITS - 1));
  localparam logic signed [ACC_W:0] DUTY_TOP =
    $signed({{(ACC_W + 1 - eps_pkg::DUTY_W){1'b0}}, eps_pkg::DUTY_MAX});

  // --------------------------------------------------------------------------
  // item capture
  eps_pkg::in_item_t in_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // period ring; entries not yet written since reset read as zero
  logic [eps_pkg::PER_W-1:0] ring_mem [PERIOD_SLOTS];
  logic [eps_pkg::PER_W-1:0] rd_q;
  logic [SLOT_W-1:0]         slot_q;
  logic                      wrapped_q;
  logic [TOTAL_W-1:0]        total_q;
  logic [eps_pkg::PHASE_W-1:0] last_phase_q;
  logic                      is_edge, wrong_dir, store_en;
  logic [eps_pkg::PER_W-1:0] old_per;

  assign is_edge = cmd_i.phase && (in_q.opcode == eps_pkg::OP_EDGE);

  always_comb begin
    wrong_dir = ((in_q.encoder_phase == 2'd0) && (last_phase_q == 2'd1)) ||
                ((in_q.encoder_phase == 2'd1) && (last_phase_q == 2'd3)) ||
                ((in_q.encoder_phase == 2'd2) && (last_phase_q == 2'd0)) ||
                ((in_q.encoder_phase == 2'd3) && (last_phase_q == 2'd2));
  end

  assign store_en = is_edge && !wrong_dir &&
                    (in_q.period_ticks > cfg_i.period_min) &&
                    (in_q.period_ticks < cfg_i.period_max);
  assign old_per  = wrapped_q ? rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      ring_mem[slot_q] <= in_q.period_ticks;
    end
    rd_q <= ring_mem[slot_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q       <= '0;
      wrapped_q    <= 1'b0;
      total_q      <= '0;
      last_phase_q <= '0;
    end else begin
      if (is_edge) begin
        last_phase_q <= in_q.encoder_phase;
      end
      if (store_en) begin
        total_q <= total_q - {{SLOT_W{1'b0}}, old_per}
                           + {{SLOT_W{1'b0}}, in_q.period_ticks};
        if (slot_q == LAST_SLOT) begin
          slot_q    <= '0;
          wrapped_q <= 1'b1;
        end else begin
          slot_q <= slot_q + 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // tick counter and update flag
  logic [eps_pkg::TICK_W-1:0] tick_q, tick_inc;
  logic                       upd_q, tick_hit;

  assign tick_inc = tick_q + 1'b1;
  assign tick_hit = (tick_inc >= cfg_i.ticks_per_update);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      upd_q  <= 1'b0;
    end else if (cmd_i.phase) begin
      if (in_q.opcode == eps_pkg::OP_TICK) begin
        tick_q <= tick_hit ? '0 : tick_inc;
        upd_q  <= tick_hit;
      end else begin
        upd_q <= 1'b0;
      end
    end
  end

  assign status_o.upd = upd_q;

  // --------------------------------------------------------------------------
  // setpoint trim, truncated toward zero
  logic [eps_pkg::POT_W:0]   pot_off, pot_mag;
  logic [eps_pkg::POT_W+eps_pkg::RECIP_W-1:0] trim_prod;
  logic [TRIM_W-2:0]         trim_quo;
  logic [TRIM_W-1:0]         trim_d, trim_q;

  assign pot_off   = {1'b0, in_q.pot_sample} - {1'b0, eps_pkg::POT_MID};
  assign pot_mag   = pot_off[eps_pkg::POT_W] ? ('0 - pot_off) : pot_off;
  assign trim_prod = pot_mag[eps_pkg::POT_W-1:0] * eps_pkg::TRIM_RECIP;
  assign trim_quo  = trim_prod[eps_pkg::TRIM_SHIFT+TRIM_W-2:eps_pkg::TRIM_SHIFT];
  assign trim_d    = pot_off[eps_pkg::POT_W] ? ('0 - {1'b0, trim_quo}) : {1'b0, trim_quo};

  always_ff @(posedge clk_i) begin
    if (cmd_i.phase) begin
      trim_q <= trim_d;
    end
  end

  // --------------------------------------------------------------------------
  // restoring divider, one quotient bit per cycle: speed_scale / total
  logic [TOTAL_W:0]            rem_q, rem_sh;
  logic [eps_pkg::SCALE_W-1:0] quo_q;
  logic                        rem_ge;
  logic [eps_pkg::SPEED_W-1:0] speed_q;

  assign rem_sh = {rem_q[TOTAL_W-1:0], quo_q[eps_pkg::SCALE_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, total_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.phase) begin
      rem_q <= '0;
      quo_q <= cfg_i.speed_scale;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? (rem_sh - {1'b0, total_q}) : rem_sh;
      quo_q <= {quo_q[eps_pkg::SCALE_W-2:0], rem_ge};
    end
    if (cmd_i.spd_load) begin
      if (total_q == '0) begin
        speed_q <= '0;
      end else if (|quo_q[eps_pkg::SCALE_W-1:eps_pkg::SPEED_W]) begin
        speed_q <= eps_pkg::SPEED_MAX;
      end else begin
        speed_q <= quo_q[eps_pkg::SPEED_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // PI law on one shared multiplier
  // err is diff << F, so the rounded Q products with dt and kp reduce to diff * gain
  logic signed [DIFF_W-1:0]          diff_d, diff_q;
  logic signed [eps_pkg::MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0]         mul_b;
  logic signed [PROD_W-1:0]          mul_p, prod_q;
  logic [ACC_W-1:0]                  integ_q, pterm_q;
  logic [eps_pkg::DUTY_W-1:0]        duty_q, duty_d;
  logic signed [PROD_W-1:0]          iterm_rnd;
  logic [ACC_W-1:0]                  iterm;
  logic signed [ACC_W:0]             pi_sum, pi_shift;

  assign diff_d = $signed({{(DIFF_W - eps_pkg::TGT_W){1'b0}}, in_q.target_speed})
                + $signed({{(DIFF_W - TRIM_W){trim_q[TRIM_W-1]}}, trim_q})
                - $signed({{(DIFF_W - eps_pkg::SPEED_W){1'b0}}, speed_q});

  always_comb begin
    mul_a = $signed({1'b0, cfg_i.ki});
    mul_b = $signed({integ_q[ACC_W-1], integ_q});
    if (cmd_i.pi_mul_dt) begin
      mul_a = $signed({1'b0, cfg_i.dt_step});
      mul_b = $signed({{(MUL_B_W - DIFF_W){diff_q[DIFF_W-1]}}, diff_q});
    end else if (cmd_i.pi_mul_kp) begin
      mul_a = $signed({1'b0, cfg_i.kp});
      mul_b = $signed({{(MUL_B_W - DIFF_W){diff_q[DIFF_W-1]}}, diff_q});
    end
  end

  assign mul_p = mul_a * mul_b;

  assign iterm_rnd = prod_q + RND;
  assign iterm     = iterm_rnd[FRACTION_BITS+ACC_W-1:FRACTION_BITS];
  assign pi_sum    = $signed({pterm_q[ACC_W-1], pterm_q}) + $signed({iterm[ACC_W-1], iterm});
  assign pi_shift  = pi_sum >>> FRACTION_BITS;

  always_comb begin
    if (pi_shift[ACC_W]) begin
      duty_d = '0;
    end else if (pi_shift > DUTY_TOP) begin
      duty_d = eps_pkg::DUTY_MAX;
    end else begin
      duty_d = pi_shift[eps_pkg::DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pi_diff) begin
      diff_q <= diff_d;
    end
    if (cmd_i.pi_mul_dt || cmd_i.pi_mul_kp || cmd_i.pi_mul_ki) begin
      prod_q <= mul_p;
    end
    // prod_q holds kp * diff while the ki product is formed
    if (cmd_i.pi_mul_ki) begin
      pterm_q <= prod_q[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      duty_q  <= '0;
    end else begin
      if (cmd_i.pi_mul_kp) begin
        integ_q <= integ_q + prod_q[ACC_W-1:0];
      end
      if (cmd_i.pi_duty) begin
        duty_q <= duty_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  eps_pkg::out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.pwm_duty       <= duty_q;
      out_q.measured_speed <= speed_q;
      out_q.duty_updated   <= upd_q;
    end
  end

  assign out_data_o = out_q;

endmodule

/* src/encoder_pi_speed_controller.sv */
// ----------------------------------------------------------------------------
// encoder_pi_speed_controller: encoder-fed PI motor speed controller
// Averages encoder edge periods in a ring, measures speed by division and
// runs a Q-format PI law every N timer ticks to set the PWM duty.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------
//  in      | in  | in_valid_i/in_ready_o   | in_data_i  (eps_pkg::in_item_t)
//  out     | out | out_valid_o/out_ready_i | out_data_o (eps_pkg::out_item_t)
//  cfg     | in  | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
//  One item in flight. The result is loaded once the item has passed the
//  edge/tick update, the 24-step speed divider, the speed load and, when it
//  runs a control update, the PI steps; the divider takes most of the time.
//  in_ready_o rises together with out_valid_o when the result is loaded.
//  A waiting result sits in the output register while the next item is taken;
//  a stalled output holds the sequencer before its load step.
//  Reset is asynchronous and clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module encoder_pi_speed_controller #(
  parameter int unsigned PERIOD_SLOTS  = 16,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  eps_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output eps_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [eps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [eps_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  eps_pkg::cfg_t       cfg;
  eps_pkg::dp_cmd_t    cmd;
  eps_pkg::dp_status_t status;

  eps_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  eps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  eps_dp #(
    .PERIOD_SLOTS  (PERIOD_SLOTS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

/* src/eps_checker.sv */
// ----------------------------------------------------------------------------
// eps_checker: port-level checks for the speed controller
// Watches transfers on both channels and the duty carried by results.
// ----------------------------------------------------------------------------
module eps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input eps_pkg::out_item_t out_data_o
);

  logic                       in_xfer, out_xfer;
  logic [1:0]                 pend_q;
  logic [eps_pkg::DUTY_W-1:0] duty_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      duty_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_xfer} - {1'b0, out_xfer};
      if (out_xfer) begin
        duty_q <= out_data_o.pwm_duty;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken while an item is in progress");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without a pending item");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many items outstanding");

  a_duty_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.duty_updated |-> out_data_o.pwm_duty == duty_q)
    else $error("duty changed without a control update");

endmodule

bind encoder_pi_speed_controller eps_checker u_eps_checker (.*);

/* verif/speed_ctrl_check.sv */
// ----------------------------------------------------------------------------
// speed_ctrl_check: result checker for the encoder PI speed controller
// Watches the config port and both item channels, runs its own model of the
// period ring, tick counter and PI law on each input transfer, and compares
// every output transfer with the oldest queued result, field by field.
// ----------------------------------------------------------------------------
module speed_ctrl_check
  import eps_pkg::*;
#(
  parameter int unsigned PERIOD_SLOTS  = 16,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    results_seen_o,
  output int                    mismatches_o
);

  localparam longint TRIM_DIV = 51;

  cfg_t                            ctrl_cfg;
  logic [PHASE_W-1:0]              last_phase;
  logic [PER_W-1:0]                period_ring [PERIOD_SLOTS];
  logic [$clog2(PERIOD_SLOTS)-1:0] ring_slot;
  logic [31:0]                     period_sum;
  logic [ACC_W-1:0]                err_integral;
  logic [TICK_W-1:0]               tick_cnt;
  logic [DUTY_W-1:0]               duty_now;
  out_item_t                       speed_duty_q [$];

  function automatic longint to_s32(logic [31:0] u);
    int s;
    s = u;
    return s;
  endfunction

  // rounded fixed-point product, wrapped to 32 bits signed
  function automatic longint q_mul(longint a, longint b);
    longint p;
    p = (a * b + (longint'(1) << (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    return to_s32(p[31:0]);
  endfunction

  function automatic logic [SPEED_W-1:0] rpm_now();
    longint q;
    if (period_sum == 0) return '0;
    q = longint'(ctrl_cfg.speed_scale) / longint'(period_sum);
    return (q > 65535) ? SPEED_MAX : q[SPEED_W-1:0];
  endfunction

  task automatic step_controller(input in_item_t it, output out_item_t res);
    logic   wrong_dir;
    longint dev, trim, setpoint, err, integ, drive;
    res.duty_updated = 1'b0;
    if (it.opcode == OP_EDGE) begin
      wrong_dir = (it.encoder_phase == 2'd0 && last_phase == 2'd1) ||
                  (it.encoder_phase == 2'd1 && last_phase == 2'd3) ||
                  (it.encoder_phase == 2'd2 && last_phase == 2'd0) ||
                  (it.encoder_phase == 2'd3 && last_phase == 2'd2);
      last_phase = it.encoder_phase;
      if (!wrong_dir && it.period_ticks > ctrl_cfg.period_min &&
          it.period_ticks < ctrl_cfg.period_max) begin
        period_sum = period_sum - period_ring[ring_slot] + it.period_ticks;
        period_ring[ring_slot] = it.period_ticks;
        ring_slot = ring_slot + 1'b1;
      end
    end else begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= ctrl_cfg.ticks_per_update) begin
        dev = longint'(it.pot_sample) - longint'(POT_MID);
        trim = dev / TRIM_DIV;  // truncates toward zero
        setpoint = longint'(it.target_speed) + trim;
        err = (setpoint - longint'(rpm_now())) * (longint'(1) << FRACTION_BITS);
        integ = to_s32(err_integral) + q_mul(err, longint'(ctrl_cfg.dt_step));
        err_integral = integ[31:0];
        drive = q_mul(longint'(ctrl_cfg.kp), err) +
                q_mul(longint'(ctrl_cfg.ki), to_s32(err_integral));
        drive = drive >>> FRACTION_BITS;
        if (drive > 255) drive = 255;
        if (drive < 0) drive = 0;
        duty_now = drive[DUTY_W-1:0];
        tick_cnt = '0;
        res.duty_updated = 1'b1;
      end
    end
    res.pwm_duty = duty_now;
    res.measured_speed = rpm_now();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want, got;
    int        errs;
    if (!rst_ni) begin
      ctrl_cfg.kp               = KP_RST;
      ctrl_cfg.ki               = KI_RST;
      ctrl_cfg.dt_step          = DT_RST;
      ctrl_cfg.period_min       = PMIN_RST;
      ctrl_cfg.period_max       = PMAX_RST;
      ctrl_cfg.speed_scale      = SCALE_RST;
      ctrl_cfg.ticks_per_update = TICKS_RST;
      last_phase = '0;
      for (int k = 0; k < PERIOD_SLOTS; k++) period_ring[k] = '0;
      ring_slot = '0;
      period_sum = '0;
      err_integral = '0;
      tick_cnt = '0;
      duty_now = '0;
      speed_duty_q.delete();
      results_seen_o <= 0;
      mismatches_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KP:         ctrl_cfg.kp = cfg_data_i[GAIN_W-1:0];
          REG_KI:         ctrl_cfg.ki = cfg_data_i[GAIN_W-1:0];
          REG_DT_STEP:    ctrl_cfg.dt_step = cfg_data_i[GAIN_W-1:0];
          REG_PERIOD_MIN: ctrl_cfg.period_min = cfg_data_i[PER_W-1:0];
          REG_PERIOD_MAX: ctrl_cfg.period_max = cfg_data_i[PER_W-1:0];
          REG_SCALE:      ctrl_cfg.speed_scale = cfg_data_i[SCALE_W-1:0];
          REG_TICKS:      ctrl_cfg.ticks_per_update = cfg_data_i[TICK_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        errs = 0;
        if (speed_duty_q.size() == 0) begin
          $error("result transfer with no outstanding item: %p", out_data_i);
          errs++;
        end else begin
          want = speed_duty_q.pop_front();
          if (want.pwm_duty !== out_data_i.pwm_duty) begin
            $error("pwm_duty: expected %0d, got %0d", want.pwm_duty, out_data_i.pwm_duty);
            errs++;
          end
          if (want.measured_speed !== out_data_i.measured_speed) begin
            $error("measured_speed: expected %0d, got %0d",
                   want.measured_speed, out_data_i.measured_speed);
            errs++;
          end
          if (want.duty_updated !== out_data_i.duty_updated) begin
            $error("duty_updated: expected %0d, got %0d",
                   want.duty_updated, out_data_i.duty_updated);
            errs++;
          end
        end
        mismatches_o <= mismatches_o + errs;
        results_seen_o <= results_seen_o + 1;
      end
      if (in_valid_i && in_ready_i) begin
        step_controller(in_data_i, got);
        speed_duty_q.push_back(got);
      end
    end
  end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: top level for the encoder PI speed controller
// Resets the block, then runs phases of directed and random encoder edges and
// timer ticks under different register settings and flow-control pressure.
// Checking is done by speed_ctrl_check; this level gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import eps_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int NUM_PHASES    = 8;
  localparam int ITEMS_PER_PHS = 162;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // next phase for forward rotation, indexed by current phase
  localparam logic [PHASE_W-1:0] FWD_PHASE [4] = '{2'd1, 2'd3, 2'd0, 2'd2};
  localparam int SEND_IDLE [4] = '{0, 58, 0, 32};
  localparam int RECV_STALL [4] = '{0, 0, 58, 32};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int results_seen, mismatches;
  int items_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycle_cnt = 0;

  logic [PER_W-1:0]   pmin_cfg = PMIN_RST;
  logic [PER_W-1:0]   pmax_cfg = PMAX_RST;
  logic [TICK_W-1:0]  ticks_cfg = TICKS_RST;
  logic [PHASE_W-1:0] enc_phase = '0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  encoder_pi_speed_controller DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  speed_ctrl_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_i     (out_data_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .results_seen_o (results_seen),
    .mismatches_o   (mismatches)
  );

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  function automatic in_item_t mk_edge(logic [PHASE_W-1:0] ph, logic [PER_W-1:0] per);
    in_item_t it;
    it = '0;
    it.opcode = OP_EDGE;
    it.encoder_phase = ph;
    it.period_ticks = per;
    return it;
  endfunction

  function automatic in_item_t mk_tick(logic [TGT_W-1:0] tgt, logic [POT_W-1:0] pot);
    in_item_t it;
    it = '0;
    it.opcode = OP_TICK;
    it.target_speed = tgt;
    it.pot_sample = pot;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic program_phase(input int k);
    logic [GAIN_W-1:0] kp, ki, dt;
    logic [23:0]       scale;
    logic [CFG_DATA_W-1:0] junk;
    if (k == 0) return;  // run the reset values first
    if (k == 1) begin
      kp = '1; ki = '1; dt = '1;
      pmin_cfg = '0; pmax_cfg = '1;
      scale = '1; ticks_cfg = 8'd1;
    end else if (k == 2) begin
      kp = '0; ki = '0; dt = '0;
      pmin_cfg = '1; pmax_cfg = '0;
      scale = 24'd1; ticks_cfg = '1;
    end else begin
      kp = ($urandom_range(3) == 0) ? GAIN_W'($urandom_range(65535))
                                    : GAIN_W'($urandom_range(2048));
      ki = ($urandom_range(3) == 0) ? GAIN_W'($urandom_range(65535))
                                    : GAIN_W'($urandom_range(2048));
      dt = ($urandom_range(3) == 0) ? GAIN_W'($urandom_range(65535))
                                    : GAIN_W'($urandom_range(100));
      pmin_cfg = PER_W'($urandom_range(2000));
      pmax_cfg = pmin_cfg + PER_W'($urandom_range(50, 30000));
      scale = ($urandom_range(1) == 0) ? 24'($urandom_range(100000, 3000000))
                                       : 24'($urandom_range(1, 24'hFFFFFF));
      ticks_cfg = ($urandom_range(4) == 0) ? TICK_W'($urandom_range(5, 255))
                                           : TICK_W'($urandom_range(1, 4));
    end
    // upper data bits beyond a register's width must be dropped
    junk = CFG_DATA_W'($urandom) & 24'hFF0000;
    write_reg(REG_KP, junk | kp);
    write_reg(REG_KI, junk | ki);
    write_reg(REG_DT_STEP, junk | dt);
    write_reg(REG_PERIOD_MIN, junk | pmin_cfg);
    write_reg(REG_PERIOD_MAX, junk | pmax_cfg);
    write_reg(REG_SCALE, scale);
    write_reg(REG_TICKS, (CFG_DATA_W'($urandom) & 24'hFFFF00) | ticks_cfg);
    if (k > 2) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));  // no effect
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stim
    in_item_t   seq [$];
    in_item_t   it;
    int         n_rand, tick_pct;
    logic [9:0] pot_picks [6];
    pot_picks = '{10'd0, 10'd1023, 10'd511, 10'd512, 10'd461, 10'd563};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < NUM_PHASES; k++) begin
      send_idle_pct = SEND_IDLE[k % 4];
      stall_pct = RECV_STALL[k % 4];
      program_phase(k);
      seq.delete();
      if (k == 0) begin
        seq.push_back(mk_tick(8'd0, 10'd0));        // empty ring, no update yet
        seq.push_back(mk_tick(8'd255, 10'd1023));   // update with speed 0
        seq.push_back(mk_edge(2'd1, 16'd331));      // just above the lower limit
        seq.push_back(mk_edge(2'd3, 16'd330));      // equal to lower limit
        seq.push_back(mk_edge(2'd2, 16'd15625));    // equal to upper limit
        seq.push_back(mk_edge(2'd0, 16'd15624));
        seq.push_back(mk_edge(2'd2, 16'd1000));     // reverse rotation, four ways
        seq.push_back(mk_edge(2'd3, 16'd1000));
        seq.push_back(mk_edge(2'd1, 16'd1000));
        seq.push_back(mk_edge(2'd0, 16'd1000));
        seq.push_back(mk_edge(2'd0, 16'd0));
        seq.push_back(mk_edge(2'd1, 16'hFFFF));
        it = mk_tick(8'd128, 10'd512);
        it.encoder_phase = 2'd3;
        it.period_ticks = 16'hFFFF;               // ignored on a tick
        seq.push_back(it);
        seq.push_back(mk_tick(8'd0, 10'd511));      // trim truncates to zero
        seq.push_back(mk_tick(8'd200, 10'd461));
        seq.push_back(mk_tick(8'd200, 10'd563));
        seq.push_back(mk_edge(2'd3, 16'd500));
        foreach (seq[i]) send_item(seq[i]);
        enc_phase = 2'd3;
      end

      n_rand = ITEMS_PER_PHS - seq.size();
      tick_pct = (ticks_cfg > 6) ? 85 : 35;
      for (int i = 0; i < n_rand; i++) begin
        it.encoder_phase = PHASE_W'($urandom_range(3));
        it.period_ticks = PER_W'($urandom_range(65535));
        it.target_speed = TGT_W'($urandom_range(255));
        it.pot_sample = ($urandom_range(9) == 0) ? pot_picks[$urandom_range(5)]
                                                 : POT_W'($urandom_range(1023));
        if ($urandom_range(99) < tick_pct) begin
          it.opcode = OP_TICK;
        end else begin
          it.opcode = OP_EDGE;
          if ($urandom_range(99) < 85) enc_phase = FWD_PHASE[enc_phase];
          else enc_phase = PHASE_W'($urandom_range(3));
          it.encoder_phase = enc_phase;
          if ($urandom_range(99) < 80 && pmax_cfg > pmin_cfg + 1)
            it.period_ticks = PER_W'($urandom_range(pmin_cfg + 1, pmax_cfg - 1));
        end
        send_item(it);
      end
      in_valid_i <= 1'b0;

      while (results_seen != items_sent) @(posedge clk_i);
      repeat (5) @(posedge clk_i);
    end

    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
